### src/bpd_pkg.sv
// Package for the box pair door geometry unit.
// Shared widths, the tolerance reset constant and the door kind codes; no dependencies.
package bpd_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int TOL_WIDTH       = 31;
    localparam logic [TOL_WIDTH-1:0] TOL_RESET = TOL_WIDTH'(800000);

    typedef enum logic [1:0] {
        DOOR_HORIZ = 2'd0,
        DOOR_VERT  = 2'd1,
        DOOR_POINT = 2'd2
    } t_door_kind;

endpackage

### src/bpd_box_if.sv
// Valid/ready channel carrying one box pair per transfer.
// Depends on nothing; width set by parameter W.
interface bpd_box_if #(
    parameter int W = 32
);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] a_left;
    logic signed [W-1:0] a_top;
    logic signed [W-1:0] a_right;
    logic signed [W-1:0] a_bottom;
    logic signed [W-1:0] b_left;
    logic signed [W-1:0] b_top;
    logic signed [W-1:0] b_right;
    logic signed [W-1:0] b_bottom;

    modport source (
        output valid, a_left, a_top, a_right, a_bottom,
               b_left, b_top, b_right, b_bottom,
        input  ready
    );
    modport sink (
        input  valid, a_left, a_top, a_right, a_bottom,
               b_left, b_top, b_right, b_bottom,
        output ready
    );
endinterface

### src/bpd_door_if.sv
// Valid/ready channel carrying one door result per transfer.
// Depends on nothing; width set by parameter W.
interface bpd_door_if #(
    parameter int W = 32
);
    logic                valid;
    logic                ready;
    logic                door_found;
    logic [1:0]          door_kind;
    logic signed [W-1:0] start_x;
    logic signed [W-1:0] start_y;
    logic signed [W-1:0] end_x;
    logic signed [W-1:0] end_y;

    modport source (
        output valid, door_found, door_kind, start_x, start_y, end_x, end_y,
        input  ready
    );
    modport sink (
        input  valid, door_found, door_kind, start_x, start_y, end_x, end_y,
        output ready
    );
endinterface

### src/bpd_door_calc.sv
// Combinational door geometry for one box pair: gaps, tolerance test, midpoints.
// Depends on bpd_pkg.
module bpd_door_calc
    import bpd_pkg::*;
#(
    parameter int CW = COORD_WIDTH_DEF
) (
    input  logic signed [CW-1:0]        i_al,
    input  logic signed [CW-1:0]        i_at,
    input  logic signed [CW-1:0]        i_ar,
    input  logic signed [CW-1:0]        i_ab,
    input  logic signed [CW-1:0]        i_bl,
    input  logic signed [CW-1:0]        i_bt,
    input  logic signed [CW-1:0]        i_br,
    input  logic signed [CW-1:0]        i_bb,
    input  logic [TOL_WIDTH-1:0]        i_tol,
    output logic                        o_found,
    output t_door_kind                  o_kind,
    output logic signed [CW-1:0]        o_sx,
    output logic signed [CW-1:0]        o_sy,
    output logic signed [CW-1:0]        o_ex,
    output logic signed [CW-1:0]        o_ey
);

    localparam int CMPW = (CW + 1 > TOL_WIDTH + 1) ? CW + 1 : TOL_WIDTH + 1;

    logic signed [CW:0]     dh1, dh2, dv1, dv2, hgap, vgap, maxgap;
    logic signed [CMPW-1:0] hgap_w, vgap_w, maxgap_w, tol_w;
    logic                   right, below, h_neg, v_neg;
    logic                   h_ok, v_ok, max_ok;
    logic signed [CW:0]     xsum, ysum, xadj, yadj;
    logic signed [CW-1:0]   xmid, ymid, lo_x, hi_x, lo_y, hi_y;

    assign dh1 = $signed({i_al[CW-1], i_al}) - $signed({i_br[CW-1], i_br});
    assign dh2 = $signed({i_bl[CW-1], i_bl}) - $signed({i_ar[CW-1], i_ar});
    assign dv1 = $signed({i_at[CW-1], i_at}) - $signed({i_bb[CW-1], i_bb});
    assign dv2 = $signed({i_bt[CW-1], i_bt}) - $signed({i_ab[CW-1], i_ab});

    assign hgap   = (dh1 > dh2) ? dh1 : dh2;
    assign vgap   = (dv1 > dv2) ? dv1 : dv2;
    assign maxgap = (hgap > vgap) ? hgap : vgap;

    assign hgap_w   = CMPW'(hgap);
    assign vgap_w   = CMPW'(vgap);
    assign maxgap_w = CMPW'(maxgap);
    assign tol_w    = CMPW'($signed({1'b0, i_tol}));

    assign h_neg  = hgap[CW];
    assign v_neg  = vgap[CW];
    assign h_ok   = (hgap_w <= tol_w);
    assign v_ok   = (vgap_w <= tol_w);
    assign max_ok = (maxgap_w <= tol_w);

    assign right = (i_bl >= i_ar);
    assign below = (i_bt >= i_ab);

    // midpoints, halved toward zero
    assign xsum = right ? ($signed({i_ar[CW-1], i_ar}) + $signed({i_bl[CW-1], i_bl}))
                        : ($signed({i_br[CW-1], i_br}) + $signed({i_al[CW-1], i_al}));
    assign ysum = below ? ($signed({i_ab[CW-1], i_ab}) + $signed({i_bt[CW-1], i_bt}))
                        : ($signed({i_bb[CW-1], i_bb}) + $signed({i_at[CW-1], i_at}));
    assign xadj = xsum + $signed({{CW{1'b0}}, xsum[CW]});
    assign yadj = ysum + $signed({{CW{1'b0}}, ysum[CW]});
    assign xmid = xadj[CW:1];
    assign ymid = yadj[CW:1];

    assign lo_x = (i_al > i_bl) ? i_al : i_bl;
    assign hi_x = (i_ar < i_br) ? i_ar : i_br;
    assign lo_y = (i_at > i_bt) ? i_at : i_bt;
    assign hi_y = (i_ab < i_bb) ? i_ab : i_bb;

    always_comb begin
        o_found = 1'b0;
        o_kind  = DOOR_HORIZ;
        o_sx    = '0;
        o_sy    = '0;
        o_ex    = '0;
        o_ey    = '0;
        if (h_neg && !v_neg && v_ok) begin
            o_found = 1'b1;
            o_kind  = DOOR_HORIZ;
            o_sx    = lo_x;
            o_ex    = hi_x;
            o_sy    = ymid;
            o_ey    = ymid;
        end else if (v_neg && !h_neg && h_ok) begin
            o_found = 1'b1;
            o_kind  = DOOR_VERT;
            o_sy    = lo_y;
            o_ey    = hi_y;
            o_sx    = xmid;
            o_ex    = xmid;
        end else if (!h_neg && !v_neg && max_ok) begin
            o_found = 1'b1;
            o_kind  = DOOR_POINT;
            o_sx    = xmid;
            o_ex    = xmid;
            o_sy    = ymid;
            o_ey    = ymid;
        end
    end

endmodule

### src/box_pair_door_geometry_unit.sv
// Box pair door geometry unit: top level.
// Sustains one pair per cycle while the output is not stalled.
// Input register, door calculation, result register; both registers hold under
// back-pressure, and a stalled output stops the input once the input register is full.
// Synchronous active-low reset clears the valid flags and sets the tolerance
// to 800000. Depends on bpd_pkg, bpd_box_if, bpd_door_if, bpd_door_calc.
module box_pair_door_geometry_unit
    import bpd_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [TOL_WIDTH-1:0] i_cfg_wdata,
    bpd_box_if.sink              i_box,
    bpd_door_if.source           o_door
);

    localparam int CW = COORD_WIDTH;

    logic [TOL_WIDTH-1:0] r_tol;
    logic                 r_in_valid, r_out_valid;
    logic signed [CW-1:0] r_al, r_at, r_ar, r_ab, r_bl, r_bt, r_br, r_bb;
    logic                 r_found;
    t_door_kind           r_kind;
    logic signed [CW-1:0] r_sx, r_sy, r_ex, r_ey;

    logic                 advance, in_take;
    logic                 c_found;
    t_door_kind           c_kind;
    logic signed [CW-1:0] c_sx, c_sy, c_ex, c_ey;

    assign advance     = !r_out_valid || o_door.ready;
    assign i_box.ready = !r_in_valid || advance;
    assign in_take     = i_box.valid && i_box.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= TOL_RESET;
        end else if (i_cfg_we) begin
            r_tol <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_box.ready) begin
            r_in_valid <= i_box.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_al <= i_box.a_left;
            r_at <= i_box.a_top;
            r_ar <= i_box.a_right;
            r_ab <= i_box.a_bottom;
            r_bl <= i_box.b_left;
            r_bt <= i_box.b_top;
            r_br <= i_box.b_right;
            r_bb <= i_box.b_bottom;
        end
    end

    bpd_door_calc #(
        .CW (CW)
    ) u_calc (
        .i_al    (r_al),
        .i_at    (r_at),
        .i_ar    (r_ar),
        .i_ab    (r_ab),
        .i_bl    (r_bl),
        .i_bt    (r_bt),
        .i_br    (r_br),
        .i_bb    (r_bb),
        .i_tol   (r_tol),
        .o_found (c_found),
        .o_kind  (c_kind),
        .o_sx    (c_sx),
        .o_sy    (c_sy),
        .o_ex    (c_ex),
        .o_ey    (c_ey)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_valid) begin
            r_found <= c_found;
            r_kind  <= c_kind;
            r_sx    <= c_sx;
            r_sy    <= c_sy;
            r_ex    <= c_ex;
            r_ey    <= c_ey;
        end
    end

    assign o_door.valid      = r_out_valid;
    assign o_door.door_found = r_found;
    assign o_door.door_kind  = r_kind;
    assign o_door.start_x    = r_sx;
    assign o_door.start_y    = r_sy;
    assign o_door.end_x      = r_ex;
    assign o_door.end_y      = r_ey;

endmodule
